// ===== design/tlwad_pkg.sv =====
package tlwad_pkg;

  localparam int unsigned L1_ENTRIES         = 4096;
  localparam int unsigned L2_ENTRIES         = 256;
  localparam int unsigned L2_TABLE_COUNT_DEF = 8;

  localparam int unsigned S_TDATA_W = 80;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 8;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_WR_L1  = 2'd1;
  localparam logic [1:0] CMD_WR_L2  = 2'd2;

  localparam logic [1:0] L1_COARSE  = 2'b01;
  localparam logic [1:0] L1_SECTION = 2'b10;

  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_WR_L1,
    OP_WR_L2,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    MT_FAULT = 2'd0,
    MT_WB    = 2'd1,
    MT_NC    = 2'd2,
    MT_DEV   = 2'd3
  } mem_type_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_L1,
    B_L2
  } back_state_e;

  typedef struct packed {
    op_e         op;
    logic [19:0] va_hi;
    logic [11:0] idx;
    logic [31:0] desc;
  } q_entry_t;

  function automatic mem_type_e decode_type(logic c, logic b, logic [2:0] tex);
    mem_type_e mt;
    if (c) begin
      mt = MT_WB;
    end else if (tex == 3'd1) begin
      mt = MT_NC;
    end else if (b) begin
      mt = MT_DEV;
    end else begin
      mt = MT_FAULT;
    end
    return mt;
  endfunction

endpackage

// ===== design/tlwad_front.sv =====
module tlwad_front #(
  parameter int unsigned L2_TABLE_COUNT = tlwad_pkg::L2_TABLE_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_valid_i,
  output logic                             s_ready_o,
  input  logic [tlwad_pkg::S_TDATA_W-1:0]  s_data_i,
  input  logic [tlwad_pkg::S_TUSER_W-1:0]  s_user_i,
  output logic                             q_valid_o,
  output tlwad_pkg::q_entry_t              q_entry_o,
  input  logic                             q_pop_i
);
  import tlwad_pkg::*;

  localparam int unsigned PoolWords = L2_TABLE_COUNT * L2_ENTRIES;

  q_entry_t    in_entry;
  q_entry_t    fifo_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push;

  always_comb begin
    in_entry.va_hi = s_data_i[31:12];
    in_entry.idx   = s_data_i[43:32];
    in_entry.desc  = s_data_i[75:44];
    case (s_user_i)
      CMD_LOOKUP: in_entry.op = OP_LOOKUP;
      CMD_WR_L1:  in_entry.op = OP_WR_L1;
      CMD_WR_L2: begin
        if (32'(s_data_i[43:32]) < 32'(PoolWords)) begin
          in_entry.op = OP_WR_L2;
        end else begin
          in_entry.op = OP_NOP;
        end
      end
      default:    in_entry.op = OP_NOP;
    endcase
  end

  assign s_ready_o = (count_q != 2'd2);
  assign push      = s_valid_i && s_ready_o;
  assign q_valid_o = (count_q != 2'd0);
  assign q_entry_o = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_entry;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> count_q != 2'd0)
    else $error("pop from empty queue");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !q_pop_i) |=> count_q == $past(count_q) + 2'd1)
    else $error("queue count lost a push");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == 2'd2 |-> !push)
    else $error("push into full queue");

endmodule

// ===== design/tlwad_back.sv =====
module tlwad_back #(
  parameter int unsigned L2_TABLE_COUNT = tlwad_pkg::L2_TABLE_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [31:0]                      cfg_wdata_i,
  input  logic                             q_valid_i,
  input  tlwad_pkg::q_entry_t              q_entry_i,
  output logic                             q_pop_o,
  output logic                             m_valid_o,
  input  logic                             m_ready_i,
  output logic [tlwad_pkg::M_TDATA_W-1:0]  m_data_o
);
  import tlwad_pkg::*;

  localparam int unsigned PoolWords = L2_TABLE_COUNT * L2_ENTRIES;
  localparam int unsigned PoolAw    = $clog2(PoolWords);

  logic [31:0]          l1_mem [L1_ENTRIES];
  logic [31:0]          l2_mem [PoolWords];
  logic [31:0]          l1_rdata_q;
  logic [31:0]          l2_rdata_q;
  logic [7:0]           page_idx_q;
  logic [21:0]          base_q;
  back_state_e          state_q, state_d;
  logic                 out_valid_q;
  logic [M_TDATA_W-1:0] out_data_q;

  logic                 out_free;
  logic                 head_lookup;
  logic                 l1_coarse;
  logic                 in_pool;
  logic [21:0]          off;
  logic [PoolAw-1:0]    l2_raddr;
  logic                 l1_re, l1_we, l2_re, l2_we;
  logic                 res_load;
  mem_type_e            res_type;
  logic                 res_page;

  assign out_free    = !out_valid_q || m_ready_i;
  assign head_lookup = (q_entry_i.op == OP_LOOKUP);
  assign l1_coarse   = (l1_rdata_q[1:0] == L1_COARSE);
  assign off         = l1_rdata_q[31:10] - base_q;
  assign in_pool     = (off < 22'(L2_TABLE_COUNT));
  assign l2_raddr    = PoolAw'({off, page_idx_q});

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (q_valid_i && head_lookup) begin
          state_d = B_L1;
        end
      end
      B_L1: begin
        if (l1_coarse && in_pool) begin
          state_d = B_L2;
        end else if (out_free) begin
          state_d = B_IDLE;
        end
      end
      B_L2: begin
        if (out_free) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o  = 1'b0;
    l1_re    = 1'b0;
    l1_we    = 1'b0;
    l2_re    = 1'b0;
    l2_we    = 1'b0;
    res_load = 1'b0;
    res_type = MT_FAULT;
    res_page = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (q_valid_i && (head_lookup || out_free)) begin
          q_pop_o  = 1'b1;
          l1_re    = head_lookup;
          l1_we    = (q_entry_i.op == OP_WR_L1);
          l2_we    = (q_entry_i.op == OP_WR_L2);
          res_load = !head_lookup;
        end
      end
      B_L1: begin
        if (l1_coarse && in_pool) begin
          l2_re = 1'b1;
        end else if (out_free) begin
          res_load = 1'b1;
          if (l1_rdata_q[1:0] == L1_SECTION) begin
            res_type = decode_type(l1_rdata_q[3], l1_rdata_q[2], l1_rdata_q[14:12]);
          end
        end
      end
      B_L2: begin
        if (out_free) begin
          res_load = 1'b1;
          res_page = 1'b1;
          if (l2_rdata_q[1]) begin
            res_type = decode_type(l2_rdata_q[3], l2_rdata_q[2], l2_rdata_q[8:6]);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      base_q      <= '0;
    end else begin
      state_q <= state_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i[31:10];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_data_q <= M_TDATA_W'({res_page, res_type});
    end
    if (l1_re) begin
      page_idx_q <= q_entry_i.va_hi[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (l1_we) begin
      l1_mem[q_entry_i.idx] <= q_entry_i.desc;
    end
    if (l1_re) begin
      l1_rdata_q <= l1_mem[q_entry_i.va_hi[19:8]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (l2_we) begin
      l2_mem[PoolAw'(q_entry_i.idx)] <= q_entry_i.desc;
    end
    if (l2_re) begin
      l2_rdata_q <= l2_mem[l2_raddr];
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;

  a_l2_after_l1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_L2 && $past(state_q) != B_L2) |-> $past(state_q) == B_L1)
    else $error("second-level read without first-level read");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> out_free)
    else $error("result overwrites an item not yet taken");

  a_lookup_walks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && head_lookup) |=> state_q == B_L1)
    else $error("lookup popped without starting walk");

endmodule

// ===== design/two_level_table_walk_attr_decode_core.sv =====
// Flow: a write item is popped from the queue and its result registered; a
//   lookup reads the first-level table and, for an in-pool coarse descriptor,
//   the second-level table, serially. Writes pass at one item per cycle while
//   the output is not stalled; no item is popped during a lookup walk.
// Reset clears the queue, sequencer, output register and pool base; table
//   contents are undefined until written.
module two_level_table_walk_attr_decode_core #(
  parameter int unsigned L2_TABLE_COUNT = tlwad_pkg::L2_TABLE_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [31:0]                      cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // address[31:0], entry_index[43:32], descriptor[75:44]
  input  logic [tlwad_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // cmd[1:0]
  input  logic [tlwad_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // mem_type[1:0], via_page[2]
  output logic [tlwad_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
  import tlwad_pkg::*;

  q_entry_t q_entry;
  logic     q_valid;
  logic     q_pop;

  tlwad_front #(
    .L2_TABLE_COUNT(L2_TABLE_COUNT)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .s_data_i (s_axis_tdata),
    .s_user_i (s_axis_tuser),
    .q_valid_o(q_valid),
    .q_entry_o(q_entry),
    .q_pop_i  (q_pop)
  );

  tlwad_back #(
    .L2_TABLE_COUNT(L2_TABLE_COUNT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .q_valid_i  (q_valid),
    .q_entry_i  (q_entry),
    .q_pop_o    (q_pop),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata)
  );

endmodule
